// ===== rtl/preemptive_priority_scheduler_unit_defines.svh =====
// Assertion macros used by the scheduler top level.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define PPSU_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that must hold in the clock cycle after the antecedent.
`define PPSU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ppsu_pkg.sv =====
// Shared constants and types for the preemptive priority scheduler.
package ppsu_pkg;

  localparam int MAX_PROCS   = 16;
  localparam int IDX_W       = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W       = $clog2(MAX_PROCS + 1);
  localparam int ARR_W       = 16;
  localparam int BURST_W     = 16;
  localparam int PRIO_W      = 8;
  localparam int PIDX_W      = 4;
  localparam int OUT_W       = 21;
  // Worst case finish: latest arrival plus every burst run back to back.
  localparam int TICK_W      = $clog2(65536 * (MAX_PROCS + 1));
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_PAD_W   = OUT_TDATA_W - PIDX_W - 3 * OUT_W;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = 1;
  localparam int Q_CNT_W     = 2;

  // One process record as classified by the front end.
  typedef struct packed {
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic               last;
    logic               zero_burst;
  } rec_t;

  // Status of the scheduling engine seen by the top level.
  typedef struct packed {
    logic             loading;
    logic [CNT_W-1:0] loaded;
  } core_stat_t;

endpackage

// ===== rtl/ppsu_front.sv =====
// Front end: accepts records, classifies them and queues them for the engine.
module ppsu_front
  import ppsu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tlast,
  output logic                  rec_valid,
  input  logic                  rec_ready,
  output rec_t                  rec,
  output logic [Q_CNT_W-1:0]    q_cnt
);

  rec_t                q_mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                push, pop;
  rec_t                new_rec;

  assign in_tready = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign rec_valid = (cnt_r != '0);
  assign pop       = rec_valid && rec_ready;
  assign rec       = q_mem_r[rd_ptr_r];
  assign q_cnt     = cnt_r;

  always_comb begin
    new_rec.arrival    = in_tdata[ARR_W-1:0];
    new_rec.burst      = in_tdata[ARR_W+BURST_W-1:ARR_W];
    new_rec.prio       = in_tdata[ARR_W+BURST_W+PRIO_W-1:ARR_W+BURST_W];
    new_rec.last       = in_tlast;
    new_rec.zero_burst = (new_rec.burst == '0);
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CNT_W'(push) - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_rec;
    end
  end

endmodule

// ===== rtl/ppsu_core.sv =====
// Back end: process tables, event-driven schedule sweep and result output.
module ppsu_core
  import ppsu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rec_valid,
  output logic              rec_ready,
  input  rec_t              rec,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PIDX_W-1:0] out_pidx,
  output logic [OUT_W-1:0]  out_cmp,
  output logic [OUT_W-1:0]  out_tat,
  output logic [OUT_W-1:0]  out_wt,
  output logic              out_last,
  output core_stat_t        stat
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_STEP,
    ST_OUT
  } state_t;

  state_t               state_r;
  logic [ARR_W-1:0]     arr_r [MAX_PROCS];
  logic [BURST_W-1:0]   bst_r [MAX_PROCS];
  logic [BURST_W-1:0]   rem_r [MAX_PROCS];
  logic [PRIO_W-1:0]    pri_r [MAX_PROCS];
  logic [OUT_W-1:0]     cmp_r [MAX_PROCS];
  logic [CNT_W-1:0]     loaded_r;
  logic [IDX_W-1:0]     idx_r;
  logic [TICK_W-1:0]    tick_r;
  logic                 found_r, have_next_r;
  logic [PRIO_W-1:0]    best_r;
  logic [IDX_W-1:0]     pick_r;
  logic [BURST_W-1:0]   pick_rem_r;
  logic [ARR_W-1:0]     next_arr_r;
  logic                 out_valid_r, out_last_r;
  logic [PIDX_W-1:0]    out_pidx_r;
  logic [OUT_W-1:0]     out_cmp_r, out_tat_r, out_wt_r;

  logic [ARR_W-1:0]     e_arr;
  logic [BURST_W-1:0]   e_rem;
  logic [PRIO_W-1:0]    e_pri;
  logic                 e_active, e_ready, take, nxt_cand, at_end;
  logic [CNT_W-1:0]     loaded_inc;
  logic [TICK_W-1:0]    gap, run, tick_after;
  logic [BURST_W-1:0]   rem_after;
  logic [OUT_W-1:0]     o_cmp, o_tat, o_wt;
  logic                 pop, out_free;

  assign rec_ready = (state_r == ST_LOAD);
  assign pop       = rec_valid && rec_ready;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    e_arr    = arr_r[idx_r];
    e_rem    = rem_r[idx_r];
    e_pri    = pri_r[idx_r];
    e_active = (e_rem != '0);
    e_ready  = (TICK_W'(e_arr) <= tick_r);
    take     = e_active && e_ready && (!found_r || e_pri < best_r);
    nxt_cand = e_active && !e_ready && (!have_next_r || e_arr < next_arr_r);
    at_end   = (CNT_W'(idx_r) + CNT_W'(1) == loaded_r);
    loaded_inc = loaded_r + CNT_W'(1);

    // run until the next arrival or until the picked process finishes
    gap        = TICK_W'(next_arr_r) - tick_r;
    run        = (have_next_r && gap < TICK_W'(pick_rem_r)) ? gap : TICK_W'(pick_rem_r);
    tick_after = tick_r + run;
    rem_after  = pick_rem_r - run[BURST_W-1:0];

    o_cmp = cmp_r[idx_r];
    o_tat = o_cmp - OUT_W'(e_arr);
    o_wt  = o_tat - OUT_W'(bst_r[idx_r]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      loaded_r    <= '0;
      idx_r       <= '0;
      tick_r      <= '0;
      found_r     <= 1'b0;
      have_next_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // result taken and no new one issued this cycle
      if (out_valid_r && out_ready && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_LOAD: begin
          if (pop) begin
            if (loaded_r < CNT_W'(MAX_PROCS)) begin
              loaded_r <= loaded_inc;
            end
            if (rec.last) begin
              state_r     <= ST_SCAN;
              idx_r       <= '0;
              tick_r      <= '0;
              found_r     <= 1'b0;
              have_next_r <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          if (take) begin
            found_r    <= 1'b1;
            best_r     <= e_pri;
            pick_r     <= idx_r;
            pick_rem_r <= e_rem;
          end
          if (nxt_cand) begin
            have_next_r <= 1'b1;
            next_arr_r  <= e_arr;
          end
          if (at_end) begin
            state_r <= ST_STEP;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_STEP: begin
          idx_r       <= '0;
          found_r     <= 1'b0;
          have_next_r <= 1'b0;
          if (found_r) begin
            tick_r  <= tick_after;
            state_r <= ST_SCAN;
          end else if (have_next_r) begin
            tick_r  <= TICK_W'(next_arr_r);
            state_r <= ST_SCAN;
          end else begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_pidx_r  <= PIDX_W'(idx_r);
            out_cmp_r   <= o_cmp;
            out_tat_r   <= o_tat;
            out_wt_r    <= o_wt;
            out_last_r  <= at_end;
            if (at_end) begin
              state_r  <= ST_LOAD;
              loaded_r <= '0;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  // table writes: loading at the fill position, schedule updates at the pick
  always_ff @(posedge clk) begin
    if (state_r == ST_LOAD && pop && loaded_r < CNT_W'(MAX_PROCS)) begin
      arr_r[loaded_r[IDX_W-1:0]] <= rec.arrival;
      bst_r[loaded_r[IDX_W-1:0]] <= rec.burst;
      rem_r[loaded_r[IDX_W-1:0]] <= rec.burst;
      pri_r[loaded_r[IDX_W-1:0]] <= rec.prio;
      if (rec.zero_burst) begin
        cmp_r[loaded_r[IDX_W-1:0]] <= OUT_W'(rec.arrival);
      end
    end else if (state_r == ST_STEP && found_r) begin
      rem_r[pick_r] <= rem_after;
      if (rem_after == '0) begin
        cmp_r[pick_r] <= tick_after[OUT_W-1:0];
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pidx     = out_pidx_r;
  assign out_cmp      = out_cmp_r;
  assign out_tat      = out_tat_r;
  assign out_wt       = out_wt_r;
  assign out_last     = out_last_r;
  assign stat.loading = (state_r == ST_LOAD);
  assign stat.loaded  = loaded_r;

endmodule

// ===== rtl/preemptive_priority_scheduler_unit.sv =====
// Top level of the preemptive priority scheduler.
// Process records (arrival tick, burst length, priority) stream in on the
// in_ channel and are stored in load order, up to MAX_PROCS of them; records
// beyond that are dropped. The record with in_tlast set closes the batch and
// starts a unit-tick preemptive priority schedule from tick zero: the ready,
// unfinished process with the smallest priority number runs, the earliest
// loaded wins a tie, and the clock idles when nothing is ready. Afterwards
// one result per process leaves on the out_ channel in load order, carrying
// completion tick, turnaround and waiting time, with out_tlast on the last
// one. Records load at one item per cycle through a two-entry queue. The
// schedule works from event to event (an arrival, a completion or an idle
// jump): each event costs one sweep over the loaded table, and a batch of N
// processes has at most about 2N events. The results then leave at one item
// per cycle while out_tready is high. No record is taken from the queue
// until the batch's results are all issued.
`include "preemptive_priority_scheduler_unit_defines.svh"

module preemptive_priority_scheduler_unit
  import ppsu_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [15:0] arrival_tick, [31:16] burst_ticks, [39:32] priority_level
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,     // last_process
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [3:0] process_index, [24:4] completion_tick, [45:25] turnaround_ticks,
  // [66:46] waiting_ticks, [71:67] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast     // last_result
);

  logic               rec_valid, rec_ready;
  rec_t               rec;
  logic [Q_CNT_W-1:0] q_cnt;
  core_stat_t         stat;
  logic [PIDX_W-1:0]  res_pidx;
  logic [OUT_W-1:0]   res_cmp, res_tat, res_wt;

  // front: accept and classify records
  ppsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec),
    .q_cnt     (q_cnt)
  );

  // back: tables, schedule sweep and result register
  ppsu_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pidx  (res_pidx),
    .out_cmp   (res_cmp),
    .out_tat   (res_tat),
    .out_wt    (res_wt),
    .out_last  (out_tlast),
    .stat      (stat)
  );

  assign out_tdata = {OUT_PAD_W'(0), res_wt, res_tat, res_cmp, res_pidx};

  // queue occupancy never runs past its depth
  `PPSU_ASSERT_NOW(a_q_bound, q_cnt <= Q_CNT_W'(Q_DEPTH), "record queue overrun")
  // table fill never exceeds its size
  `PPSU_ASSERT_NOW(a_fill_bound, stat.loaded <= CNT_W'(MAX_PROCS), "table overfilled")
  // results of one batch follow without gaps while the sink keeps up
  `PPSU_ASSERT_NXT(a_res_burst, out_tvalid && out_tready && !out_tlast, out_tvalid,
                   "gap inside a result run")

endmodule

// ===== tb/sv/preemptive_priority_scheduler_unit_tb.sv =====
// Self-checking testbench for the preemptive priority scheduler unit.
`timescale 1ns / 1ps

module preemptive_priority_scheduler_unit_tb;
  import ppsu_pkg::*;

  // One per-process report as it leaves the out_ channel.
  typedef struct packed {
    logic [PIDX_W-1:0] idx;
    logic [OUT_W-1:0]  done_tick;
    logic [OUT_W-1:0]  turnaround;
    logic [OUT_W-1:0]  waiting;
    logic              last;
  } proc_report_t;

  localparam int DRAIN_CYCLES = 1000;  // worst batch: ~2N sweeps over the table, plus output

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // [15:0] arrival_tick, [31:16] burst_ticks, [39:32] priority_level
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tlast   = 1'b0;  // last_process
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [3:0] process_index, [24:4] completion_tick, [45:25] turnaround_ticks,
  // [66:46] waiting_ticks, [71:67] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;  // last_result

  // Predictor copy of the loaded batch
  logic [ARR_W-1:0]   stored_arrival [MAX_PROCS];
  logic [BURST_W-1:0] stored_burst   [MAX_PROCS];
  logic [PRIO_W-1:0]  stored_prio    [MAX_PROCS];
  int unsigned        stored_count = 0;

  proc_report_t expected_reports[$];

  int unsigned mismatches      = 0;
  int unsigned reports_checked = 0;
  int unsigned records_sent    = 0;
  int unsigned batches_sent    = 0;
  int unsigned overflow_drops  = 0;
  bit          steady          = 1'b0;  // no idling on either side while set

  preemptive_priority_scheduler_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  // Result side back-pressure: ~9% stalls, none while steady
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 9);
  end

  task automatic note_error(input string msg);
    if (mismatches < 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // Unit-tick preemptive priority schedule of the stored batch, worked out
  // event to event: the choice can only change at an arrival or completion.
  function automatic void schedule_batch();
    int unsigned  left      [MAX_PROCS];
    int unsigned  finish_at [MAX_PROCS];
    int unsigned  now;
    int unsigned  finished;
    int unsigned  span;
    int unsigned  next_arrival;
    int           sel;
    bit           arrival_ahead;
    proc_report_t rep;
    now = 0;
    finished = 0;
    for (int i = 0; i < stored_count; i++) left[i] = 32'(stored_burst[i]);
    while (finished < stored_count) begin
      sel = -1;
      arrival_ahead = 1'b0;
      next_arrival = 0;
      for (int i = 0; i < stored_count; i++) begin
        if (left[i] == 0) continue;
        if (32'(stored_arrival[i]) <= now) begin
          // strict compare keeps the earliest loaded on a tie
          if (sel < 0 || stored_prio[i] < stored_prio[sel]) sel = i;
        end else if (!arrival_ahead || 32'(stored_arrival[i]) < next_arrival) begin
          arrival_ahead = 1'b1;
          next_arrival = 32'(stored_arrival[i]);
        end
      end
      if (sel < 0) begin
        now = next_arrival;  // idle stretch
      end else begin
        span = left[sel];
        if (arrival_ahead && next_arrival - now < span) span = next_arrival - now;
        now += span;
        left[sel] -= span;
        if (left[sel] == 0) begin
          finish_at[sel] = now;
          finished++;
        end
      end
    end
    for (int i = 0; i < stored_count; i++) begin
      rep.idx        = PIDX_W'(i);
      rep.done_tick  = OUT_W'(finish_at[i]);
      rep.turnaround = rep.done_tick - OUT_W'(stored_arrival[i]);
      rep.waiting    = rep.turnaround - OUT_W'(stored_burst[i]);
      rep.last       = (i + 1 == stored_count);
      expected_reports.push_back(rep);
    end
    stored_count = 0;
  endfunction

  // Sends one record and updates the prediction once it is taken.
  task automatic send_record(input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] burst,
                             input logic [PRIO_W-1:0] prio, input logic last);
    if (!steady && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {prio, burst, arr};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    records_sent++;
    if (stored_count < MAX_PROCS) begin
      stored_arrival[stored_count] = arr;
      stored_burst[stored_count]   = burst;
      stored_prio[stored_count]    = prio;
      stored_count++;
    end else begin
      overflow_drops++;  // table full: dropped, but a last mark still counts
    end
    if (last) begin
      schedule_batch();
      batches_sent++;
    end
  endtask

  // Holds the sender off until every predicted report has been seen.
  task automatic drain_reports();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  // Report checker
  always @(posedge clk) begin
    proc_report_t want;
    proc_report_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[3:0], out_tdata[24:4], out_tdata[45:25], out_tdata[66:46], out_tlast};
      if (expected_reports.size() == 0) begin
        note_error($sformatf("unexpected report idx %0d done %0d", got.idx, got.done_tick));
      end else begin
        want = expected_reports.pop_front();
        reports_checked++;
        if (got.idx != want.idx || got.done_tick != want.done_tick ||
            got.turnaround != want.turnaround || got.waiting != want.waiting ||
            got.last != want.last || out_tdata[71:67] != '0) begin
          note_error($sformatf({"report mismatch: exp idx %0d done %0d tat %0d wait %0d last %0b",
                                " / got idx %0d done %0d tat %0d wait %0d last %0b pad %0h"},
                               want.idx, want.done_tick, want.turnaround, want.waiting,
                               want.last, got.idx, got.done_tick, got.turnaround, got.waiting,
                               got.last, out_tdata[71:67]));
        end
      end
    end
  end

  // Lone process with every field at its top value
  task automatic test_single_extreme();
    send_record(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    drain_reports();
  endtask

  // Preemption by a better priority, ties on priority, and an idle gap
  task automatic test_preemption();
    send_record(16'd0,  16'd5, 8'd3, 1'b0);
    send_record(16'd1,  16'd2, 8'd1, 1'b0);
    send_record(16'd2,  16'd2, 8'd1, 1'b0);
    send_record(16'd3,  16'd1, 8'd0, 1'b0);
    send_record(16'd40, 16'd3, 8'd7, 1'b0);
    send_record(16'd40, 16'd1, 8'd7, 1'b1);
    drain_reports();
  endtask

  // Full table plus two dropped records, the last of them closing the batch
  task automatic test_table_overflow();
    for (int k = 0; k < MAX_PROCS + 2; k++) begin
      send_record(k[3] ? 16'hFFFF : 16'(k), (k == 5) ? 16'hFFFF : 16'(k + 1),
                  k[0] ? 8'h00 : 8'hFF, k == MAX_PROCS + 1);
    end
    drain_reports();
  endtask

  task automatic send_random_batch(input int unsigned count);
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    int unsigned        style;
    for (int unsigned k = 0; k < count; k++) begin
      style = $urandom_range(99);
      if (style < 70) begin
        // dense, overlapping arrivals: plenty of preemption and ties
        arr   = ARR_W'($urandom_range(63));
        burst = BURST_W'($urandom_range(32, 1));
        prio  = PRIO_W'($urandom_range(3));
      end else if (style < 90) begin
        arr   = ARR_W'($urandom);
        burst = BURST_W'($urandom_range(65535, 1));
        prio  = PRIO_W'($urandom);
      end else begin
        arr   = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        burst = $urandom_range(1) ? 16'hFFFF : 16'h0001;
        prio  = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      send_record(arr, burst, prio, k + 1 == count);
    end
  endtask

  function automatic int unsigned random_batch_size();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 80) return $urandom_range(6, 1);
    if (pick < 92) return $urandom_range(MAX_PROCS, 7);
    return $urandom_range(MAX_PROCS + 4, MAX_PROCS + 1);
  endfunction

  // Random batches with idling on both sides; pauses for a full drain now and then
  task automatic test_random_batches(input int unsigned records);
    int unsigned stop_at;
    stop_at = records_sent + records;
    while (records_sent < stop_at) begin
      send_random_batch(random_batch_size());
      if ($urandom_range(7) == 0) drain_reports();
    end
    drain_reports();
  endtask

  // Long stretch with no idling on either side
  task automatic test_back_to_back(input int unsigned records);
    int unsigned stop_at;
    steady = 1'b1;
    stop_at = records_sent + records;
    while (records_sent < stop_at) send_random_batch(random_batch_size());
    drain_reports();
    steady = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_extreme();
    test_preemption();
    test_table_overflow();
    test_random_batches(230);
    test_back_to_back(70);

    // catch any stray report before closing
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_reports.size() != 0) begin
      note_error($sformatf("%0d reports never arrived", expected_reports.size()));
    end

    $display("Sent %0d records in %0d batches (%0d dropped on a full table), checked %0d reports",
             records_sent, batches_sent, overflow_drops, reports_checked);
    $display("Covered preemption, priority ties, idle gaps, field extremes and stall-free runs");
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Timeout with %0d reports outstanding", expected_reports.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
